// File: rtl/thtc_pkg.sv
// Shared types and constants for the two-pad tap/hold classifier.
// No dependencies. Imported by thtc_pad and touch_tap_hold_classifier.
`timescale 1ns / 1ps
`default_nettype none

package thtc_pkg;

    localparam int CNT_W   = 16;
    localparam int TALLY_W = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CNT_W-1:0] TAP_WINDOW_RESET = 16'd400;
    localparam logic [CNT_W-1:0] HOLD_RESET       = 16'd1200;

    // configuration register indexes
    localparam logic CFG_TAP_WINDOW = 1'b0;
    localparam logic CFG_HOLD       = 1'b1;

    typedef enum logic [1:0] {
        GEST_NONE = 2'd0,
        GEST_TAPS = 2'd1,
        GEST_HOLD = 2'd2
    } gesture_t;

    typedef struct packed {
        logic [CNT_W-1:0] tap_window;
        logic [CNT_W-1:0] hold;
    } cfg_t;

    typedef struct packed {
        gesture_t           gesture;
        logic [TALLY_W-1:0] taps;
    } pad_result_t;

endpackage : thtc_pkg

`default_nettype wire

// File: rtl/thtc_skid.sv
// Two-entry output skid buffer; registered ready on the upstream side.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module thtc_skid #(
    parameter int WIDTH = 12
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output      logic             in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output      logic             out_valid,
    input  wire logic             out_ready,
    output      logic [WIDTH-1:0] out_data
);

    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic [WIDTH-1:0] out_data_reg;
    logic [WIDTH-1:0] skid_data_reg;
    logic             load_out;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign load_out  = out_ready || !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_valid;
            end
        end
        else if (in_valid && in_ready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (in_valid && in_ready)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule : thtc_skid

`default_nettype wire

// File: rtl/thtc_pad.sv
// One pad: state registers and the single-tick update of press/tap/window.
// Depends on thtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module thtc_pad
    import thtc_pkg::*;
#(
    parameter int MAX_TAPS = 15
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic        level,
    input  wire cfg_t        cfg,
    output      pad_result_t result
);

    localparam logic [TALLY_W-1:0] TALLY_CAP =
        (MAX_TAPS > 15) ? TALLY_W'(15) : TALLY_W'(MAX_TAPS);

    logic               pressed_reg, pressed_next;
    logic               hold_reg, hold_next;
    logic [CNT_W-1:0]   press_len_reg, press_len_next;
    logic [CNT_W-1:0]   window_reg, window_next;
    logic [TALLY_W-1:0] tally_reg, tally_next;

    always_comb
    begin
        pressed_next   = pressed_reg;
        hold_next      = hold_reg;
        press_len_next = press_len_reg;
        tally_next     = tally_reg;
        window_next    = window_reg;
        result.gesture = GEST_NONE;
        result.taps    = '0;

        if (tally_reg != '0 && window_reg != CNT_MAX)
        begin
            window_next = window_reg + CNT_W'(1);
        end

        if (level)
        begin
            pressed_next = 1'b1;
            if (!pressed_reg)
            begin
                press_len_next = '0;
                hold_next      = 1'b0;
            end
            if (press_len_next != CNT_MAX)
            begin
                press_len_next = press_len_next + CNT_W'(1);
            end
            if (!hold_next && press_len_next > cfg.hold)
            begin
                hold_next  = 1'b1;
                tally_next = '0;
            end
        end
        else if (pressed_reg && hold_reg)
        begin
            // end of a long press
            pressed_next   = 1'b0;
            press_len_next = '0;
            hold_next      = 1'b0;
            tally_next     = '0;
            result.gesture = GEST_HOLD;
        end
        else
        begin
            if (pressed_reg)
            begin
                pressed_next   = 1'b0;
                press_len_next = '0;
                if (tally_reg < TALLY_CAP)
                begin
                    tally_next = tally_reg + TALLY_W'(1);
                end
                if (tally_next == TALLY_W'(1))
                begin
                    window_next = '0;
                end
            end
            if (tally_next != '0 && window_next > cfg.tap_window)
            begin
                result.gesture = GEST_TAPS;
                result.taps    = tally_next;
                tally_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg   <= 1'b0;
            hold_reg      <= 1'b0;
            press_len_reg <= '0;
            window_reg    <= '0;
            tally_reg     <= '0;
        end
        else if (step)
        begin
            pressed_reg   <= pressed_next;
            hold_reg      <= hold_next;
            press_len_reg <= press_len_next;
            window_reg    <= window_next;
            tally_reg     <= tally_next;
        end
    end

endmodule : thtc_pad

`default_nettype wire

// File: rtl/touch_tap_hold_classifier.sv
// Top level of the two-pad tap/hold classifier: config registers, pad units,
// output skid buffer. Depends on thtc_pkg, thtc_pad, thtc_skid.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake               Content
// s_axis    in   s_axis_tvalid/tready    one tick: both pad levels
// m_axis    out  m_axis_tvalid/tready    one result per tick: gesture+taps per pad
// cfg       in   cfg_valid/cfg_ready     register index + 16-bit value
//
// One beat in, one beat out, one beat per clock sustained while m_axis is not
// stalled. Pad state updates at the accepting edge; the result is registered
// there in the two-entry output buffer, which keeps s_axis_tready registered;
// a stall on m_axis drops s_axis_tready after one more beat is absorbed.
// Reset restores tap window 400 and hold 1200 and clears all pad state.
// cfg_ready is always high; writes are expected only while idle.

module touch_tap_hold_classifier
    import thtc_pkg::*;
#(
    parameter int MAX_TAPS  = 15,   // 2..255, tally saturates at min(MAX_TAPS, 15)
    parameter int PAD_COUNT = 2     // 1..8, pads past the second never report
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // [0] pad_one_level, [1] pad_two_level, [7:2] zero
    input  wire logic [7:0]  s_axis_tdata,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // [1:0] pad_one_event, [5:2] pad_one_taps, [7:6] pad_two_event,
    // [11:8] pad_two_taps, [15:12] zero
    output      logic [15:0] m_axis_tdata,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int RES_W = 2 * $bits(pad_result_t);

    cfg_t        cfg_reg;
    logic        step;
    logic        pad_level [PAD_COUNT];
    pad_result_t pad_res   [PAD_COUNT];
    pad_result_t res_one, res_two;
    logic [RES_W-1:0] res_data, buf_data;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tap_window <= TAP_WINDOW_RESET;
            cfg_reg.hold       <= HOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TAP_WINDOW: cfg_reg.tap_window <= cfg_data;
                CFG_HOLD:       cfg_reg.hold       <= cfg_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // Every accepted tick advances every pad
    assign step = s_axis_tvalid && s_axis_tready;

    for (genvar p = 0; p < PAD_COUNT; p++)
    begin : g_pad
        // pads beyond the second see a released level
        if (p < 2)
        begin : g_lvl
            assign pad_level[p] = s_axis_tdata[p];
        end
        else
        begin : g_idle
            assign pad_level[p] = 1'b0;
        end

        thtc_pad #(
            .MAX_TAPS (MAX_TAPS)
        ) u_pad (
            .clk    (clk),
            .rst_n  (rst_n),
            .step   (step),
            .level  (pad_level[p]),
            .cfg    (cfg_reg),
            .result (pad_res[p])
        );
    end

    assign res_one = pad_res[0];

    if (PAD_COUNT > 1)
    begin : g_two
        assign res_two = pad_res[1];
    end
    else
    begin : g_one
        assign res_two = '{gesture: GEST_NONE, taps: '0};
    end

    assign res_data = {res_two.taps, res_two.gesture, res_one.taps, res_one.gesture};

    thtc_skid #(
        .WIDTH (RES_W)
    ) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (step),
        .in_ready  (s_axis_tready),
        .in_data   (res_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (buf_data)
    );

    assign m_axis_tdata = {4'b0000, buf_data};

    // Assertions

    // a gesture code of 3 never leaves the block for pad one
    a_pad_one_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("pad one gesture code out of range");

    // taps only accompany a tap-group report
    a_pad_one_taps: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] != GEST_TAPS) |-> m_axis_tdata[5:2] == 4'd0)
        else $error("pad one taps without tap group");

    a_pad_two_taps: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[7:6] != GEST_TAPS) |-> m_axis_tdata[11:8] == 4'd0)
        else $error("pad two taps without tap group");

    // input stalls only after an output stall absorbed a beat
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready && step))
        else $error("input stalled without output backpressure");

endmodule : touch_tap_hold_classifier

`default_nettype wire

// File: tb/tap_hold_checker.sv
// Checker for the two-pad tap/hold classifier: watches the tick, result and config
// channels, predicts each result beat and compares it field by field.
// Depends on thtc_pkg (gesture codes, register indexes, reset values).
`timescale 1ns / 1ps

module tap_hold_checker
    import thtc_pkg::*;
#(
    parameter int MAX_TAPS = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          mismatches,
    output int          outstanding
);

    localparam logic [TALLY_W-1:0] TALLY_CAP = (MAX_TAPS > 15) ? 4'd15 : MAX_TAPS[TALLY_W-1:0];

    typedef struct packed {
        pad_result_t one;
        pad_result_t two;
    } tick_result_t;

    tick_result_t expected_ticks[$];

    // predicted register and pad state
    logic [CNT_W-1:0]   window_limit;
    logic [CNT_W-1:0]   hold_limit;
    logic               pressed      [2];
    logic [CNT_W-1:0]   press_len    [2];
    logic               hold_flag    [2];
    logic [TALLY_W-1:0] tally        [2];
    logic [CNT_W-1:0]   since_first  [2];

    // one tick of one pad; updates the predicted state
    function automatic pad_result_t classify_pad(input int p, input logic level);
        pad_result_t res;
        res.gesture = GEST_NONE;
        res.taps    = '0;
        if (tally[p] != 0 && since_first[p] != CNT_MAX)
            since_first[p] = since_first[p] + 1'b1;
        if (level) begin
            if (!pressed[p]) begin
                pressed[p]   = 1'b1;
                press_len[p] = '0;
                hold_flag[p] = 1'b0;
            end
            if (press_len[p] != CNT_MAX)
                press_len[p] = press_len[p] + 1'b1;
            if (!hold_flag[p] && press_len[p] > hold_limit) begin
                hold_flag[p] = 1'b1;
                tally[p]     = '0;
            end
            return res;
        end
        if (pressed[p]) begin
            pressed[p]   = 1'b0;
            press_len[p] = '0;
            if (hold_flag[p]) begin
                hold_flag[p] = 1'b0;
                tally[p]     = '0;
                res.gesture  = GEST_HOLD;
                return res;
            end
            if (tally[p] < TALLY_CAP)
                tally[p] = tally[p] + 1'b1;
            if (tally[p] == 1)
                since_first[p] = '0;
        end
        if (tally[p] != 0 && since_first[p] > window_limit) begin
            res.gesture = GEST_TAPS;
            res.taps    = tally[p];
            tally[p]    = '0;
        end
        return res;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        tick_result_t want;
        tick_result_t pred;
        if (!rst_n) begin
            window_limit = TAP_WINDOW_RESET;
            hold_limit   = HOLD_RESET;
            for (int p = 0; p < 2; p++) begin
                pressed[p]     = 1'b0;
                press_len[p]   = '0;
                hold_flag[p]   = 1'b0;
                tally[p]       = '0;
                since_first[p] = '0;
            end
            expected_ticks.delete();
            mismatches  = 0;
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_TAP_WINDOW)
                    window_limit = cfg_data;
                else
                    hold_limit = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pred.one = classify_pad(0, s_axis_tdata[0]);
                pred.two = classify_pad(1, s_axis_tdata[1]);
                expected_ticks.push_back(pred);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_ticks.size() == 0) begin
                    $error("result beat with no tick outstanding: %h", m_axis_tdata);
                    mismatches++;
                end else begin
                    want = expected_ticks.pop_front();
                    compare_field("pad_one_event", int'(want.one.gesture),
                                  int'(m_axis_tdata[1:0]));
                    compare_field("pad_one_taps",  int'(want.one.taps),
                                  int'(m_axis_tdata[5:2]));
                    compare_field("pad_two_event", int'(want.two.gesture),
                                  int'(m_axis_tdata[7:6]));
                    compare_field("pad_two_taps",  int'(want.two.taps),
                                  int'(m_axis_tdata[11:8]));
                end
            end
            outstanding <= expected_ticks.size();
        end
    end

endmodule

// File: tb/touch_tap_hold_classifier_tb.sv
// Testbench top for touch_tap_hold_classifier: clock, reset, tick stimulus,
// result back-pressure and config writes; verdict from tap_hold_checker.
// Depends on thtc_pkg, touch_tap_hold_classifier and tap_hold_checker.
`timescale 1ns / 1ps

module touch_tap_hold_classifier_tb;
    import thtc_pkg::*;

    localparam int TAP_LIMIT   = 15;
    // the slowest legal run, about 500 ticks at worst-case gaps and stalls plus
    // drains, ends well before this limit
    localparam int CYCLE_LIMIT = 100_000;
    localparam int PHASE_TICKS = 60;

    logic        clk;
    logic        rst_n;
    logic [7:0]  s_axis_tdata;   // [0] pad_one_level, [1] pad_two_level, [7:2] zero
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] m_axis_tdata;   // [1:0] pad_one_event, [5:2] pad_one_taps,
                                 // [7:6] pad_two_event, [11:8] pad_two_taps, [15:12] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    int          mismatches;
    int          outstanding;
    int          cycle_count = 0;

    // quiet = no gaps on the sender, no stalls on the receiver
    logic        quiet;

    // what the stimulus believes the registers hold, for shaping press lengths
    int          cur_window;
    int          cur_hold;

    // per-pad run generator for the random part
    logic        run_level [2];
    int          run_left  [2];

    touch_tap_hold_classifier #(
        .MAX_TAPS (TAP_LIMIT)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    tap_hold_checker #(
        .MAX_TAPS (TAP_LIMIT)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: a hang or a lost result ends here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result sink. After each accepted result beat, tready drops for a random
    // number of cycles (none while quiet). Driven at the falling edge only.
    initial
    begin : result_sink
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
                m_axis_tready <= 1'b1;
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                stall = quiet ? 0 : $urandom_range(0, 10);
        end
    end

    // One tick beat. Entered and left at a falling edge. tvalid only drops when
    // a gap is drawn, so it is never lowered and raised in the same step.
    task automatic send_tick(input logic one, input logic two);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= {6'b0, two, one};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
        @(negedge clk);
    endtask

    task automatic ticks(input logic one, input logic two, input int count);
        repeat (count) send_tick(one, two);
    endtask

    // Hold the sender off until every predicted result has come back.
    // Each tick yields exactly one result, so an empty queue means idle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic idx, input int value);
        cfg_index <= idx;
        cfg_data  <= value[15:0];
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        @(negedge clk);
    endtask

    // Only called with the block idle (after reset or after drain).
    task automatic set_config(input int window, input int hold);
        write_reg(CFG_TAP_WINDOW, window);
        write_reg(CFG_HOLD, hold);
        cfg_valid  <= 1'b0;
        cur_window = window;
        cur_hold   = hold;
    endtask

    // Start a new run for one pad: mostly alternating press/release with
    // lengths around the thresholds, sometimes a one-tick noise sample.
    task automatic pick_run(input int p);
        if ($urandom_range(0, 9) == 0)
        begin
            run_level[p] = 1'($urandom_range(0, 1));
            run_left[p]  = 1;
        end
        else
        begin
            run_level[p] = !run_level[p];
            if (run_level[p])
            begin
                // short press (tap) or just past the hold threshold
                if ($urandom_range(0, 9) < 7 || cur_hold >= 200)
                    run_left[p] = $urandom_range(1, (cur_hold < 40) ? cur_hold : 40);
                else
                    run_left[p] = cur_hold + $urandom_range(1, 4);
            end
            else
            begin
                // gap inside the window (multi-tap) or long enough to report
                if ($urandom_range(0, 9) < 6 || cur_window >= 200)
                    run_left[p] = $urandom_range(1, (cur_window < 40) ? cur_window : 40);
                else
                    run_left[p] = cur_window + $urandom_range(0, 3);
            end
        end
    endtask

    initial
    begin : stimulus
        int window;
        int hold;
        rst_n         = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tvalid = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_TAP_WINDOW;
        cfg_data      = '0;
        quiet         = 1'b0;
        cur_window    = int'(TAP_WINDOW_RESET);
        cur_hold      = int'(HOLD_RESET);
        run_level     = '{1'b0, 1'b0};
        run_left      = '{0, 0};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: taps stay pending under the 400-tick window
        ticks(1, 0, 1);
        ticks(0, 1, 1);
        ticks(0, 0, 2);
        drain();

        // small thresholds: window 3, hold after 4 ticks pressed
        set_config(3, 4);
        ticks(0, 0, 5);            // flush whatever the defaults left pending
        ticks(1, 1, 1);
        ticks(0, 0, 1);            // both pads: first tap, window restarts
        ticks(1, 0, 1);
        ticks(0, 0, 5);            // pad one: double tap reported
        ticks(0, 1, 6);
        ticks(0, 0, 1);            // pad two: hold on release, no taps
        ticks(1, 0, 1);
        ticks(0, 0, 1);
        ticks(1, 0, 6);            // pad one: long press drops the pending tap
        ticks(0, 0, 1);
        ticks(0, 1, 1);
        ticks(0, 0, 1);
        ticks(0, 1, 4);            // pad two: window runs out while still pressed
        ticks(0, 0, 1);            // reported only now, as two taps
        drain();

        // tap count saturation: 17 quick taps inside a wide window
        set_config(60, 2);
        for (int i = 0; i < 17; i++)
        begin
            ticks(1, 1, 1);
            ticks(0, 0, 1);
        end
        ticks(0, 0, 64);
        drain();

        // random part: several register settings, the extremes among them;
        // odd phases run with no gaps and no stalls
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin window = 1;                     hold = 1;                     end
                1: begin window = 2;                     hold = 7;                     end
                2: begin window = $urandom_range(1, 24); hold = $urandom_range(1, 24); end
                3: begin window = 30;                    hold = 3;                     end
                4: begin window = 65535;                 hold = 1;                     end
                default: begin window = 1;               hold = 65535;                 end
            endcase
            if (ph == 5)
                window = $urandom_range(1, 24);
            set_config(window, hold);
            quiet = ph[0];
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                for (int p = 0; p < 2; p++)
                begin
                    if (run_left[p] == 0)
                        pick_run(p);
                    run_left[p]--;
                end
                send_tick(run_level[0], run_level[1]);
                if ($urandom_range(0, 63) == 0)
                    drain();
            end
            drain();
        end
        quiet = 1'b0;

        drain();
        repeat (4) @(negedge clk); // room for a stray beat to show up
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
